// ===== rtl/core/hpd_pkg.sv =====
// Package for the heading PD controller: beat payload types, the
// configuration register set, register indexes and arithmetic constants.
// No dependencies.
package hpd_pkg;

  localparam int HEADING_W = 12;
  localparam int PULSE_W   = 16;
  localparam int GAIN_W    = 8;
  localparam int ERR_W     = 12;
  // Raw heading difference and error change both need one extra bit.
  localparam int DIFF_W    = ERR_W + 1;
  localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W  = GAIN_W + 1 + DIFF_W;
  localparam int SUM_W     = PROD_D_W + 1;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam logic signed [DIFF_W-1:0] WRAP_HALF = 13'sd1800;
  localparam logic signed [DIFF_W-1:0] WRAP_FULL = 13'sd3600;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P  = 8'd100;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D  = 8'd10;
  localparam logic [PULSE_W-1:0] RST_NEUTRAL = 16'd2765;
  localparam logic [PULSE_W-1:0] RST_MINIMUM = 16'd2028;
  localparam logic [PULSE_W-1:0] RST_MAXIMUM = 16'd3502;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_GAIN_P  = 3'd0;
  localparam logic [2:0] REG_GAIN_D  = 3'd1;
  localparam logic [2:0] REG_NEUTRAL = 3'd2;
  localparam logic [2:0] REG_MINIMUM = 3'd3;
  localparam logic [2:0] REG_MAXIMUM = 3'd4;

  typedef struct packed {
    logic [HEADING_W-1:0] target_heading;
    logic [HEADING_W-1:0] measured_heading;
  } in_t;

  typedef struct packed {
    logic [PULSE_W-1:0]      pulse_width;
    logic signed [ERR_W-1:0] heading_error;
    logic                    clamped;
  } out_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_proportional;
    logic [GAIN_W-1:0]  gain_derivative;
    logic [PULSE_W-1:0] pulse_neutral;
    logic [PULSE_W-1:0] pulse_minimum;
    logic [PULSE_W-1:0] pulse_maximum;
  } cfg_t;

endpackage

// ===== rtl/core/hpd_regs.sv =====
// Configuration register file of the heading PD controller, written and
// read over an APB-style port. Depends on hpd_pkg.
module hpd_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hpd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [hpd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [hpd_pkg::CFG_DATA_W-1:0]   prdata,
  output hpd_pkg::cfg_t                    cfg
);
  import hpd_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN_P:  cfg_nxt.gain_proportional = pwdata[GAIN_W-1:0];
        REG_GAIN_D:  cfg_nxt.gain_derivative   = pwdata[GAIN_W-1:0];
        REG_NEUTRAL: cfg_nxt.pulse_neutral     = pwdata[PULSE_W-1:0];
        REG_MINIMUM: cfg_nxt.pulse_minimum     = pwdata[PULSE_W-1:0];
        REG_MAXIMUM: cfg_nxt.pulse_maximum     = pwdata[PULSE_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_proportional <= RST_GAIN_P;
      cfg_r.gain_derivative   <= RST_GAIN_D;
      cfg_r.pulse_neutral     <= RST_NEUTRAL;
      cfg_r.pulse_minimum     <= RST_MINIMUM;
      cfg_r.pulse_maximum     <= RST_MAXIMUM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_P:  prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, cfg_r.gain_proportional};
      REG_GAIN_D:  prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, cfg_r.gain_derivative};
      REG_NEUTRAL: prdata = {{(CFG_DATA_W-PULSE_W){1'b0}}, cfg_r.pulse_neutral};
      REG_MINIMUM: prdata = {{(CFG_DATA_W-PULSE_W){1'b0}}, cfg_r.pulse_minimum};
      REG_MAXIMUM: prdata = {{(CFG_DATA_W-PULSE_W){1'b0}}, cfg_r.pulse_maximum};
      default:     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/heading_pd_controller.sv =====
// Heading PD controller: wraps the heading error, forms the PD sum and
// clamps it to the pulse limits. Depends on hpd_pkg and hpd_regs.
// A result is registered in stage 1, stage 2 and the output stage in turn.
// Throughput: one beat per cycle unless out_ready stalls; three stages (error/delta,
// the two gain multipliers, sum and clamp) each hold one beat and fill bubbles on stall.
// Reset: synchronous, active low; clears stage valids and the previous error,
// and loads the register defaults.
module heading_pd_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hpd_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hpd_pkg::out_t                   out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hpd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [hpd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [hpd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import hpd_pkg::*;

  cfg_t cfg;

  hpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // Stage valids and per-stage ready.
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s2_ready, out_slot_ready;

  assign out_slot_ready = !out_valid_r || out_ready;
  assign s2_ready       = !s2_valid_r || out_slot_ready;
  assign in_ready       = !s1_valid_r || s2_ready;

  // Stage 1: wrapped error and change of error.
  logic signed [DIFF_W-1:0] raw_diff;
  logic signed [DIFF_W-1:0] wrapped;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [DIFF_W-1:0] delta_nxt;
  logic signed [ERR_W-1:0]  last_error_r;
  logic signed [ERR_W-1:0]  s1_err_r;
  logic signed [DIFF_W-1:0] s1_delta_r;

  assign raw_diff = $signed({1'b0, in_data.target_heading})
                  - $signed({1'b0, in_data.measured_heading});

  always_comb begin
    if (raw_diff > WRAP_HALF) begin
      wrapped = raw_diff - WRAP_FULL;
    end else if (raw_diff < -WRAP_HALF) begin
      wrapped = raw_diff + WRAP_FULL;
    end else begin
      wrapped = raw_diff;
    end
  end

  assign err_nxt   = wrapped[ERR_W-1:0];
  assign delta_nxt = {err_nxt[ERR_W-1], err_nxt} - {last_error_r[ERR_W-1], last_error_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
    end else if (in_valid && in_ready) begin
      last_error_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_err_r   <= err_nxt;
      s1_delta_r <= delta_nxt;
    end
  end

  // Stage 2: the two gain products.
  logic signed [PROD_P_W-1:0] prod_p_nxt, s2_prod_p_r;
  logic signed [PROD_D_W-1:0] prod_d_nxt, s2_prod_d_r;
  logic signed [ERR_W-1:0]    s2_err_r;

  assign prod_p_nxt = $signed({1'b0, cfg.gain_proportional}) * s1_err_r;
  assign prod_d_nxt = $signed({1'b0, cfg.gain_derivative}) * s1_delta_r;

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_ready) begin
      s2_prod_p_r <= prod_p_nxt;
      s2_prod_d_r <= prod_d_nxt;
      s2_err_r    <= s1_err_r;
    end
  end

  // Stage 3: sum with the neutral pulse, then clamp against the limits.
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lim_max, lim_min;
  out_t                    out_nxt, out_data_r;

  assign sum = $signed({{(SUM_W-PULSE_W){1'b0}}, cfg.pulse_neutral})
             + $signed({{(SUM_W-PROD_P_W){s2_prod_p_r[PROD_P_W-1]}}, s2_prod_p_r})
             + $signed({{(SUM_W-PROD_D_W){s2_prod_d_r[PROD_D_W-1]}}, s2_prod_d_r});
  assign lim_max = $signed({{(SUM_W-PULSE_W){1'b0}}, cfg.pulse_maximum});
  assign lim_min = $signed({{(SUM_W-PULSE_W){1'b0}}, cfg.pulse_minimum});

  // Maximum tested first: inverted limits give the maximum above it, else the minimum.
  always_comb begin
    out_nxt.heading_error = s2_err_r;
    if (sum > lim_max) begin
      out_nxt.pulse_width = cfg.pulse_maximum;
      out_nxt.clamped     = 1'b1;
    end else if (sum < lim_min) begin
      out_nxt.pulse_width = cfg.pulse_minimum;
      out_nxt.clamped     = 1'b1;
    end else begin
      out_nxt.pulse_width = sum[PULSE_W-1:0];
      out_nxt.clamped     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && out_slot_ready) begin
      out_data_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_slot_ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/hpd_checker.sv =====
// Port-level checks for the heading PD controller, attached by bind.
// Depends on hpd_pkg and heading_pd_controller.
module hpd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input hpd_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input hpd_pkg::out_t out_data
);
  import hpd_pkg::*;

  // An input beat that is not taken stays offered with the same payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed or dropped while stalled");

  // A result beat that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed or dropped while stalled");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The wrapped error always lies within half a turn.
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.heading_error <= 12'sd1800) &&
                  (out_data.heading_error >= -12'sd1800))
    else $error("heading error outside wrap range");

  // An empty or draining output stage must let input beats in.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while output can drain");

endmodule

bind heading_pd_controller hpd_checker u_hpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb_heading_pd_controller.sv =====
// Self-checking testbench for heading_pd_controller: drives compass samples and
// APB register writes and checks every result beat against an in-bench predictor.
// Depends on hpd_pkg and the heading_pd_controller RTL.
module tb_heading_pd_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import hpd_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_ITEMS    = 214;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  heading_pd_controller u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Shadow of the register file and of the controller's previous error.
  cfg_t gains_and_limits = '{gain_proportional: RST_GAIN_P, gain_derivative: RST_GAIN_D,
                             pulse_neutral: RST_NEUTRAL, pulse_minimum: RST_MINIMUM,
                             pulse_maximum: RST_MAXIMUM};
  int   prev_heading_error = 0;

  in_t  heading_samples[$];
  out_t expected_pulses[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int clamped_seen = 0;
  int register_writes = 0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic out_t predict_pulse(in_t s);
    out_t r;
    int   err;
    int   total;
    err = int'(s.target_heading) - int'(s.measured_heading);
    if (err > int'(WRAP_HALF)) begin
      err = err - int'(WRAP_FULL);
    end else if (err < -int'(WRAP_HALF)) begin
      err = err + int'(WRAP_FULL);
    end
    total = int'(gains_and_limits.pulse_neutral)
          + int'(gains_and_limits.gain_proportional) * err
          + int'(gains_and_limits.gain_derivative) * (err - prev_heading_error);
    // Maximum is tested first, so an inverted pair of limits still resolves.
    if (total > int'(gains_and_limits.pulse_maximum)) begin
      r.pulse_width = gains_and_limits.pulse_maximum;
      r.clamped     = 1'b1;
    end else if (total < int'(gains_and_limits.pulse_minimum)) begin
      r.pulse_width = gains_and_limits.pulse_minimum;
      r.clamped     = 1'b1;
    end else begin
      r.pulse_width = total[PULSE_W-1:0];
      r.clamped     = 1'b0;
    end
    r.heading_error = err[ERR_W-1:0];
    prev_heading_error = err;
    return r;
  endfunction

  // Driver: one beat at a time from the pending queue, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_pulses.push_back(predict_pulse(in_data));
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (heading_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= heading_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(string what, out_t want, out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected pw=%0d err=%0d clamp=%0b, got pw=%0d err=%0d clamp=%0b",
               $realtime, what, want.pulse_width, $signed(want.heading_error), want.clamped,
               got.pulse_width, $signed(got.heading_error), got.clamped);
    end
  endtask

  // Monitor: random back-pressure and in-order comparison of result beats.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.clamped) clamped_seen++;
        if (expected_pulses.size() == 0) begin
          note_mismatch("result beat with nothing expected", '0, out_data);
        end else begin
          want = expected_pulses.pop_front();
          if (out_data.pulse_width !== want.pulse_width
              || out_data.heading_error !== want.heading_error
              || out_data.clamped !== want.clamped) begin
            note_mismatch("result mismatch", want, out_data);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pulses.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain_pipeline();
    while (heading_samples.size() != 0 || in_valid || expected_pulses.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_P:  gains_and_limits.gain_proportional = value[GAIN_W-1:0];
      REG_GAIN_D:  gains_and_limits.gain_derivative   = value[GAIN_W-1:0];
      REG_NEUTRAL: gains_and_limits.pulse_neutral     = value[PULSE_W-1:0];
      REG_MINIMUM: gains_and_limits.pulse_minimum     = value[PULSE_W-1:0];
      REG_MAXIMUM: gains_and_limits.pulse_maximum     = value[PULSE_W-1:0];
      default: ;
    endcase
    register_writes++;
  endtask

  task automatic load_settings(int kp, int kd, int neutral, int lo, int hi);
    drain_pipeline();
    write_register(REG_GAIN_P, kp);
    write_register(REG_GAIN_D, kd);
    write_register(REG_NEUTRAL, neutral);
    write_register(REG_MINIMUM, lo);
    write_register(REG_MAXIMUM, hi);
  endtask

  function automatic in_t make_sample(int target, int measured);
    in_t s;
    s.target_heading   = target[HEADING_W-1:0];
    s.measured_heading = measured[HEADING_W-1:0];
    return s;
  endfunction

  // Half the samples hold a heading close to the target, so the loop is not always
  // saturated; the rest covers the whole compass and out-of-range codes.
  function automatic in_t random_sample();
    int pick;
    int t;
    pick = $urandom_range(99);
    t    = $urandom_range(3599);
    if (pick < 50) begin
      return make_sample(t, (t + $urandom_range(16) - 8 + 3600) % 3600);
    end else if (pick < 80) begin
      return make_sample(t, $urandom_range(3599));
    end
    return make_sample($urandom_range(4095), $urandom_range(4095));
  endfunction

  task automatic load_random_limits();
    int neutral;
    neutral = $urandom_range(1500, 4000);
    load_settings($urandom_range(255), $urandom_range(255), neutral,
                  neutral - $urandom_range(200, 1000), neutral + $urandom_range(200, 1000));
  endtask

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: wrap boundaries and out-of-range headings.
    @(negedge clk);
    heading_samples.push_back(make_sample(0, 0));
    heading_samples.push_back(make_sample(3599, 0));
    heading_samples.push_back(make_sample(0, 3599));
    heading_samples.push_back(make_sample(1800, 0));
    heading_samples.push_back(make_sample(0, 1800));
    heading_samples.push_back(make_sample(1801, 0));
    heading_samples.push_back(make_sample(0, 1801));
    heading_samples.push_back(make_sample(4095, 0));
    heading_samples.push_back(make_sample(0, 4095));
    heading_samples.push_back(make_sample(4095, 4095));
    heading_samples.push_back(make_sample(5, 0));
    heading_samples.push_back(make_sample(0, 5));
    heading_samples.push_back(make_sample(2, 0));

    // Sums landing exactly on each limit, just past it, and below zero.
    load_settings(1, 0, 0, 10, 20);
    @(negedge clk);
    heading_samples.push_back(make_sample(20, 0));
    heading_samples.push_back(make_sample(10, 0));
    heading_samples.push_back(make_sample(21, 0));
    heading_samples.push_back(make_sample(9, 0));
    heading_samples.push_back(make_sample(0, 5));

    // Minimum set above maximum.
    load_settings(1, 0, 500, 3000, 1000);
    @(negedge clk);
    heading_samples.push_back(make_sample(700, 0));
    heading_samples.push_back(make_sample(0, 0));
    heading_samples.push_back(make_sample(200, 0));

    // Full-scale gains and limits; writes past the last register must be ignored.
    load_settings(255, 255, 65535, 0, 65535);
    for (int i = REG_MAXIMUM + 1; i < 8; i++) begin
      write_register(i[2:0], $urandom);
    end
    @(negedge clk);
    heading_samples.push_back(make_sample(1800, 0));
    heading_samples.push_back(make_sample(0, 1800));
    heading_samples.push_back(make_sample(0, 0));

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_settings(RST_GAIN_P, RST_GAIN_D, RST_NEUTRAL, RST_MINIMUM, RST_MAXIMUM);
        2: load_settings(255, 255, 32768, 0, 65535);
        4: load_settings(0, 0, $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(65535));
        6: load_settings($urandom_range(1, 4), $urandom_range(0, 4), 2000, 1000, 3000);
        default: load_random_limits();
      endcase
      case (phase % 4)
        0: begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
        1: begin sender_idle_pct <= 61; receiver_stall_pct <= 0;  end
        2: begin sender_idle_pct <= 0;  receiver_stall_pct <= 61; end
        default: begin sender_idle_pct <= 18; receiver_stall_pct <= 18; end
      endcase
      @(negedge clk);
      for (int n = 0; n < PHASE_ITEMS / 2; n++) heading_samples.push_back(random_sample());
      // Hold the sender back until the pipeline has emptied, then resume.
      drain_pipeline();
      @(negedge clk);
      for (int n = 0; n < PHASE_ITEMS / 2; n++) heading_samples.push_back(random_sample());
    end

    drain_pipeline();
    repeat (10) @(posedge clk);
    $display("Sent %0d heading samples over 8 traffic phases with %0d register writes;",
             samples_sent, register_writes);
    $display("checked %0d result beats, %0d of them clamped.", results_seen, clamped_seen);
    if (mismatches == 0 && expected_pulses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
